### hw/rtl/euler_to_quaternion_unit_macros.svh
// Assertion macros for the Euler angle to quaternion unit.
`ifndef EULER_TO_QUATERNION_UNIT_MACROS_SVH
`define EULER_TO_QUATERNION_UNIT_MACROS_SVH
// Property holds at every clock edge outside reset.
`define E2Q_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("e2q assertion failed");
// Data offered with valid holds steady while the receiver is not ready.
`define E2Q_ASSERT_HOLD(label, clk, rst_n, vld, rdy, data) \
    label: assert property (@(posedge clk) disable iff (!rst_n) \
        (vld && !rdy) |=> $stable(data)) \
        else $error("e2q payload changed while stalled");
`endif

### hw/rtl/e2q_pkg.sv
// Package with constants, tables and helpers for the Euler to quaternion unit.
`timescale 1ns / 1ps
package e2q_pkg;
    localparam int ANGLE_FRAC_BITS_DEF = 16;
    localparam int OUT_FRAC_BITS_DEF = 14;
    localparam int CORDIC_STEPS = 30;
    localparam logic signed [33:0] CORDIC_GAIN_INIT = 34'sd652032874;

    function automatic logic [31:0] atan_turn(input int idx);
        logic [31:0] t;
        begin
            case (idx)
                0: t = 32'h20000000;  1: t = 32'h12E4051E;  2: t = 32'h09FB385B;
                3: t = 32'h051111D4;  4: t = 32'h028B0D43;  5: t = 32'h0145D7E1;
                6: t = 32'h00A2F61E;  7: t = 32'h00517C55;  8: t = 32'h0028BE53;
                9: t = 32'h00145F2F; 10: t = 32'h000A2F98; 11: t = 32'h000517CC;
                12: t = 32'h00028BE6; 13: t = 32'h000145F3; 14: t = 32'h0000A2FA;
                15: t = 32'h0000517D; 16: t = 32'h000028BE; 17: t = 32'h0000145F;
                18: t = 32'h00000A30; 19: t = 32'h00000518; 20: t = 32'h0000028C;
                21: t = 32'h00000146; 22: t = 32'h000000A3; 23: t = 32'h00000051;
                24: t = 32'h00000029; 25: t = 32'h00000014; 26: t = 32'h0000000A;
                27: t = 32'h00000005; 28: t = 32'h00000003; 29: t = 32'h00000001;
                default: t = 32'h0;
            endcase
            return t;
        end
    endfunction
endpackage

### hw/rtl/euler_to_quaternion_unit.sv
// Top level of the Euler angle to quaternion unit: a fully pipelined datapath.
// Throughput is one item per cycle while the skid slot is empty; a full skid slot stalls the pipeline.
// The pipeline stages are: wrap (4), phase (2), CORDIC (30), products (6), output (1).
// An output register with a skid slot lets input be taken while a result waits.
// Reset (rst_n, asynchronous, active low) clears all valid bits; payload is not reset.
// A stall freezes every stage at once, so no item is lost or repeated.
`timescale 1ns / 1ps
`include "euler_to_quaternion_unit_macros.svh"
module euler_to_quaternion_unit
    import e2q_pkg::*;
#(
    parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF,
    parameter int OUT_FRAC_BITS = OUT_FRAC_BITS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [31:0] pitch_deg,
    input  logic signed [31:0] yaw_deg,
    input  logic signed [31:0] roll_deg,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [15:0] quat_x,
    output logic signed [15:0] quat_y,
    output logic signed [15:0] quat_z,
    output logic signed [15:0] quat_w
);
    // Pipeline depth ahead of the output register.
    localparam int FRONT = 6;
    localparam int PROD = 6;
    localparam int DEPTH = FRONT + CORDIC_STEPS + PROD;
    localparam int SH = 60 - OUT_FRAC_BITS;
    localparam logic [39:0] M360 = 40'(360) << ANGLE_FRAC_BITS;
    // Reciprocal of 360 scaled by 2^48 (rounded up); exact for products below 2^40.
    localparam logic [40:0] RECIP = 41'd781874935308;

    // The whole datapath advances together; the skid slot absorbs the item in flight.
    logic adv;
    logic [DEPTH-1:0] v_reg;
    logic out_full_reg, skid_full_reg;

    assign adv = !skid_full_reg;
    assign in_ready = adv;

    // ---- Stage 0..3: truncating remainder by 360 for each angle ----
    // Magnitude |a| < 2^31 (plus 2^31 case). q = floor(|a| / M360) via reciprocal,
    // split into two half-width products that are summed in the next stage.
    logic [31:0] mag_reg  [3][3];
    logic        neg_reg  [3][4];
    logic [72:0] qlo_reg  [3];
    logic [72:0] qhi_reg  [3];
    logic [31:0] q_reg    [3];
    logic [39:0] r_reg    [3];
    // Stage 4..5: phase = r * 2^(31-F) / 360, again as two partial products.
    logic [81:0] ph_lo_reg[3];
    logic [81:0] ph_hi_reg[3];
    logic signed [33:0] ph_reg[3];
    logic flip0_reg[3];

    logic signed [31:0] ang_in[3];
    assign ang_in[0] = pitch_deg;
    assign ang_in[1] = yaw_deg;
    assign ang_in[2] = roll_deg;

    // Phase scaling: r < 360*2^F, r << (31-F) < 360*2^31 < 2^40; divide by 360.
    logic [39:0] shifted[3];
    logic [81:0] pq_prod[3];
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            shifted[k] = r_reg[k] << (31 - ANGLE_FRAC_BITS);
            pq_prod[k] = (ph_hi_reg[k] << 20) + ph_lo_reg[k];
        end
    end

    logic signed [33:0] ph_raw[3];
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            ph_raw[k] = 34'(pq_prod[k] >> 48);
        end
    end

    logic negp_reg[3];
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < 3; k++)
            begin
                mag_reg[k][0] <= ang_in[k][31] ? 32'(-ang_in[k]) : ang_in[k];
                neg_reg[k][0] <= ang_in[k][31];
                qlo_reg[k]    <= 73'(mag_reg[k][0][15:0]) * 73'(RECIP);
                qhi_reg[k]    <= 73'(mag_reg[k][0][31:16]) * 73'(RECIP);
                mag_reg[k][1] <= mag_reg[k][0];
                neg_reg[k][1] <= neg_reg[k][0];
                q_reg[k]      <= 32'(((qhi_reg[k] << 16) + qlo_reg[k])
                                     >> (48 + ANGLE_FRAC_BITS));
                mag_reg[k][2] <= mag_reg[k][1];
                neg_reg[k][2] <= neg_reg[k][1];
                r_reg[k]      <= 40'(mag_reg[k][2]) - 40'(q_reg[k]) * M360;
                neg_reg[k][3] <= neg_reg[k][2];
                ph_lo_reg[k]  <= 82'(shifted[k][19:0]) * 82'(RECIP);
                ph_hi_reg[k]  <= 82'(shifted[k][39:20]) * 82'(RECIP);
                negp_reg[k]   <= neg_reg[k][3];
                if (ph_raw[k] > 34'sd1073741824)
                begin
                    ph_reg[k] <= negp_reg[k] ? -(34'sd2147483648 - ph_raw[k])
                                             : 34'sd2147483648 - ph_raw[k];
                    flip0_reg[k] <= 1'b1;
                end
                else
                begin
                    ph_reg[k] <= negp_reg[k] ? -ph_raw[k] : ph_raw[k];
                    flip0_reg[k] <= 1'b0;
                end
            end
        end
    end

    // ---- CORDIC: one stage per iteration ----
    logic signed [33:0] cx_reg[3][1:CORDIC_STEPS];
    logic signed [33:0] cy_reg[3][1:CORDIC_STEPS];
    logic signed [33:0] cz_reg[3][1:CORDIC_STEPS];
    logic               cf_reg[3][1:CORDIC_STEPS];

    genvar gk, gi;
    generate
        for (gk = 0; gk < 3; gk++)
        begin : g_ang
            for (gi = 0; gi < CORDIC_STEPS; gi++)
            begin : g_step
                logic signed [33:0] x_cur, y_cur, z_cur;
                logic               f_cur;
                logic signed [33:0] dx, dy;
                // The first iteration starts from the gain constant and the folded phase.
                if (gi == 0)
                begin : g_head
                    assign x_cur = CORDIC_GAIN_INIT;
                    assign y_cur = '0;
                    assign z_cur = ph_reg[gk];
                    assign f_cur = flip0_reg[gk];
                end
                else
                begin : g_body
                    assign x_cur = cx_reg[gk][gi];
                    assign y_cur = cy_reg[gk][gi];
                    assign z_cur = cz_reg[gk][gi];
                    assign f_cur = cf_reg[gk][gi];
                end
                assign dx = y_cur >>> gi;
                assign dy = x_cur >>> gi;
                always_ff @(posedge clk)
                begin
                    if (adv)
                    begin
                        cf_reg[gk][gi+1] <= f_cur;
                        if (!z_cur[33])
                        begin
                            cx_reg[gk][gi+1] <= x_cur - dx;
                            cy_reg[gk][gi+1] <= y_cur + dy;
                            cz_reg[gk][gi+1] <= z_cur - 34'(atan_turn(gi));
                        end
                        else
                        begin
                            cx_reg[gk][gi+1] <= x_cur + dx;
                            cy_reg[gk][gi+1] <= y_cur - dy;
                            cz_reg[gk][gi+1] <= z_cur + 34'(atan_turn(gi));
                        end
                    end
                end
            end
        end
    endgenerate

    // ---- Products ----
    // s/c values are within about +-2^30, 32 bits signed.
    logic signed [31:0] s_v[3], c_v[3];
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            s_v[k] = 32'(cy_reg[k][CORDIC_STEPS]);
            c_v[k] = cf_reg[k][CORDIC_STEPS] ? 32'(-cx_reg[k][CORDIC_STEPS])
                                              : 32'(cx_reg[k][CORDIC_STEPS]);
        end
    end

    // Stage P0: register the six values; P1: four pair products cr*sp, sr*cp, cr*cp, sr*sp.
    logic signed [31:0] sp_reg, cp_reg, sy_reg, cy_reg2, sr_reg, cr_reg;
    logic signed [31:0] sy_d_reg, cy_d_reg;
    logic signed [63:0] ab_reg[4];
    logic signed [31:0] abr_reg[4];
    logic signed [31:0] sy_d2_reg, cy_d2_reg;
    // P3: eight triple products in 64 bits, cut into 32x32 products.
    logic signed [63:0] t_reg[8];
    logic signed [63:0] sum_reg[4];
    logic signed [63:0] rnd_reg[4];

    logic signed [63:0] rounded[4];
    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            rounded[k] = (ab_reg[k] + 64'sd536870912) >>> 30;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sp_reg <= s_v[0]; cp_reg <= c_v[0];
            sy_reg <= s_v[1]; cy_reg2 <= c_v[1];
            sr_reg <= s_v[2]; cr_reg <= c_v[2];
            ab_reg[0] <= 64'(cr_reg) * 64'(sp_reg);
            ab_reg[1] <= 64'(sr_reg) * 64'(cp_reg);
            ab_reg[2] <= 64'(cr_reg) * 64'(cp_reg);
            ab_reg[3] <= 64'(sr_reg) * 64'(sp_reg);
            sy_d_reg <= sy_reg; cy_d_reg <= cy_reg2;
            for (int k = 0; k < 4; k++)
            begin
                abr_reg[k] <= 32'(rounded[k]);
            end
            sy_d2_reg <= sy_d_reg; cy_d2_reg <= cy_d_reg;
            t_reg[0] <= 64'(abr_reg[0]) * 64'(sy_d2_reg);
            t_reg[1] <= 64'(abr_reg[1]) * 64'(cy_d2_reg);
            t_reg[2] <= 64'(abr_reg[0]) * 64'(cy_d2_reg);
            t_reg[3] <= 64'(abr_reg[1]) * 64'(sy_d2_reg);
            t_reg[4] <= 64'(abr_reg[2]) * 64'(sy_d2_reg);
            t_reg[5] <= 64'(abr_reg[3]) * 64'(cy_d2_reg);
            t_reg[6] <= 64'(abr_reg[2]) * 64'(cy_d2_reg);
            t_reg[7] <= 64'(abr_reg[3]) * 64'(sy_d2_reg);
            sum_reg[0] <= t_reg[0] - t_reg[1];
            sum_reg[1] <= -t_reg[2] - t_reg[3];
            sum_reg[2] <= t_reg[4] - t_reg[5];
            sum_reg[3] <= t_reg[6] + t_reg[7];
            for (int k = 0; k < 4; k++)
            begin
                rnd_reg[k] <= (sum_reg[k] + (64'sd1 <<< (SH - 1))) >>> SH;
            end
        end
    end

    // Clamp to +-one and the 16-bit field.
    localparam logic signed [63:0] ONE_V = 64'sd1 <<< OUT_FRAC_BITS;
    localparam logic signed [63:0] HI = (ONE_V > 64'sd32767) ? 64'sd32767 : ONE_V;
    localparam logic signed [63:0] LO = (-ONE_V < -64'sd32768) ? -64'sd32768 : -ONE_V;
    logic signed [15:0] q_next[4];
    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            if (rnd_reg[k] > HI)
                q_next[k] = 16'(HI);
            else if (rnd_reg[k] < LO)
                q_next[k] = 16'(LO);
            else
                q_next[k] = 16'(rnd_reg[k]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (adv)
            v_reg <= {v_reg[DEPTH-2:0], in_valid};
    end

    // ---- Output register plus skid slot ----
    logic signed [15:0] oq_reg[4], sq_reg[4];
    logic last_v;
    assign last_v = v_reg[DEPTH-1] && adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_full_reg <= 1'b0;
            skid_full_reg <= 1'b0;
        end
        else
        begin
            if (!out_full_reg || out_ready)
            begin
                out_full_reg <= skid_full_reg || last_v;
                skid_full_reg <= 1'b0;
            end
            else if (last_v)
                skid_full_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_full_reg || out_ready)
        begin
            for (int k = 0; k < 4; k++)
            begin
                oq_reg[k] <= skid_full_reg ? sq_reg[k] : q_next[k];
            end
        end
        else if (last_v)
            sq_reg <= q_next;
    end

    assign out_valid = out_full_reg;
    assign quat_x = oq_reg[0];
    assign quat_y = oq_reg[1];
    assign quat_z = oq_reg[2];
    assign quat_w = oq_reg[3];

    // All four components side by side, for the hold check.
    logic [63:0] out_word;
    assign out_word = {quat_x, quat_y, quat_z, quat_w};

    `E2Q_ASSERT(a_skid_needs_out, clk, rst_n, skid_full_reg |-> out_full_reg)
    `E2Q_ASSERT(a_no_take_on_skid, clk, rst_n, skid_full_reg |-> !in_ready)
    `E2Q_ASSERT(a_stall_hold, clk, rst_n, (out_valid && !out_ready) |=> out_valid)
    `E2Q_ASSERT_HOLD(a_out_word_hold, clk, rst_n, out_valid, out_ready, out_word)
endmodule
